/* rtl/tlvp_pkg.sv */
// Shared types and constants for the framed TLV stream parser.
package tlvp_pkg;

    // Frame layout constants
    localparam logic [15:0] HARD_MIN_LEN  = 16'd14;
    localparam logic [15:0] RECORD_START  = 16'd11;
    localparam logic [15:0] TRAILER_BYTES = 16'd3;
    localparam logic [7:0]  TRANSFER_CODE = 8'h01;

    // Reset values of the configuration registers
    localparam logic [7:0] START_MARKER_RST = 8'hEE;
    localparam logic [7:0] END_MARKER_RST   = 8'hFF;
    localparam logic [7:0] VERSION_RST      = 8'h01;
    localparam logic [7:0] MIN_LEN_RST      = 8'd14;

    // Result queue geometry
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_END_MARKER   = 2'd1,
        CFG_VERSION      = 2'd2,
        CFG_MIN_LENGTH   = 2'd3
    } cfg_index_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    // Frame end status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_TAIL     = 3'd1,
        ST_BAD_VERSION  = 3'd2,
        ST_BAD_TRANSFER = 3'd3,
        ST_BAD_LENGTH   = 3'd4
    } status_t;

    // Parser phase
    typedef enum logic {
        PH_HUNT  = 1'b0,
        PH_FRAME = 1'b1
    } phase_t;

    // Live configuration
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] expected_version;
        logic [7:0] min_frame_length;
    } cfg_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [15:0] record_id;
        logic [15:0] record_length;
        logic [7:0]  data_byte;
        logic [7:0]  frame_id;
        status_t     status;
        logic        last;
    } res_t;

    // Results produced by one accepted byte, front to queue
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

/* rtl/frame_receiver_tlv_parser_core.sv */
// Top level of the framed TLV stream parser: config registers, parser front, result queue.
//
// Usage:
//   s_* carries the received byte stream, one byte per transaction (s_tdata[7:0]).
//   m_* carries result items: record headers, record data bytes and one end status
//   per frame; m_tuser holds the kind, m_tlast marks the final result of a byte.
//   cfg_* writes one 8-bit register per transaction (index 0 start marker,
//   1 end marker, 2 expected version, 3 minimum frame length); always ready.
// Timing:
//   A byte is parsed in the cycle it is accepted and its results enter a 4-entry
//   queue at that edge; m_* is driven from the entry at the head of the queue.
//   One byte per cycle is accepted while s_tready is high; a byte makes zero, one or two results.
//   s_tready is high while the queue has room for two results, so a stalled
//   receiver backs up the queue and then holds off the input; one result leaves
//   per cycle while m_tready is high.
// Reset:
//   aresetn low empties the queue, returns the parser to hunting for the start
//   marker and loads the register defaults (0xEE, 0xFF, 0x01, 14). No init pass.
module frame_receiver_tlv_parser_core
    import tlvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] record_id, [31:16] record_length,
                                   // [39:32] data_byte, [47:40] frame_id,
                                   // [50:48] status, [55:51] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t  cfg_reg;
    push_t push;
    logic  space;
    logic  in_fire;
    res_t  out_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = space;
    assign in_fire   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker     <= START_MARKER_RST;
            cfg_reg.end_marker       <= END_MARKER_RST;
            cfg_reg.expected_version <= VERSION_RST;
            cfg_reg.min_frame_length <= MIN_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_MARKER: cfg_reg.start_marker     <= cfg_data;
                CFG_END_MARKER:   cfg_reg.end_marker       <= cfg_data;
                CFG_VERSION:      cfg_reg.expected_version <= cfg_data;
                CFG_MIN_LENGTH:   cfg_reg.min_frame_length <= cfg_data;
                default: ;
            endcase
        end
    end

    tlvp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .cfg     (cfg_reg),
        .push    (push)
    );

    tlvp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // output packing
    assign m_tdata = {5'd0, out_res.status, out_res.frame_id, out_res.data_byte,
                      out_res.record_length, out_res.record_id};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // results only come from an accepted byte
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> in_fire)
        else $error("results pushed without an accepted byte");

    // the final pushed result of a byte carries last, earlier ones do not
    a_last_marking: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd1 |-> push.r0.last) and
        (push.n == 2'd2 |-> (push.r1.last && !push.r0.last)))
        else $error("last flag misplaced among results of one byte");

    // an end status always closes the results of its byte
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_END) |-> m_tlast)
        else $error("end status without last");

    // two results in one byte only when the second is the end status
    a_pair_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> (push.r1.kind == KIND_END && push.r0.kind != KIND_END))
        else $error("result pair without frame end");

endmodule

/* rtl/tlvp_front.sv */
// Front end: byte classifier and frame/record parser, emits up to two results per byte.
module tlvp_front
    import tlvp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] frame_last_reg, frame_last_next;
    logic [15:0] rec_end_reg, rec_end_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [1:0]  flags_reg, flags_next;
    logic [1:0]  field_idx_reg, field_idx_next;
    logic [15:0] rec_id_reg, rec_id_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [15:0] data_rem_reg, data_rem_next;

    logic        emit;
    logic        bad_len;
    logic [15:0] frame_len;
    logic [15:0] new_len;
    logic        have_a, have_b;
    res_t        res_a, res_b;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            pos_reg        <= '0;
            frame_last_reg <= '0;
            rec_end_reg    <= '0;
            len_high_reg   <= '0;
            frame_id_reg   <= '0;
            flags_reg      <= '0;
            field_idx_reg  <= '0;
            rec_id_reg     <= '0;
            rec_len_reg    <= '0;
            data_rem_reg   <= '0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            frame_last_reg <= frame_last_next;
            rec_end_reg    <= rec_end_next;
            len_high_reg   <= len_high_next;
            frame_id_reg   <= frame_id_next;
            flags_reg      <= flags_next;
            field_idx_reg  <= field_idx_next;
            rec_id_reg     <= rec_id_next;
            rec_len_reg    <= rec_len_next;
            data_rem_reg   <= data_rem_next;
        end
    end

    // Next state and results for the accepted byte
    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        frame_last_next = frame_last_reg;
        rec_end_next    = rec_end_reg;
        len_high_next   = len_high_reg;
        frame_id_next   = frame_id_reg;
        flags_next      = flags_reg;
        field_idx_next  = field_idx_reg;
        rec_id_next     = rec_id_reg;
        rec_len_next    = rec_len_reg;
        data_rem_next   = data_rem_reg;
        emit            = (flags_reg == 2'b11);
        bad_len         = 1'b0;
        frame_len       = {len_high_reg, in_byte};
        new_len         = {rec_len_reg[15:8], in_byte};
        have_a          = 1'b0;
        have_b          = 1'b0;
        res_a           = '0;
        res_b           = '0;

        if (in_fire) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (in_byte == cfg.start_marker) begin
                        phase_next     = PH_FRAME;
                        pos_next       = 16'd1;
                        len_high_next  = '0;
                        frame_id_next  = '0;
                        flags_next     = '0;
                        field_idx_next = '0;
                        rec_id_next    = '0;
                        rec_len_next   = '0;
                        data_rem_next  = '0;
                    end
                end
                PH_FRAME: begin
                    // header bytes
                    if (pos_reg == 16'd1) begin
                        if (in_byte == cfg.expected_version) flags_next[0] = 1'b1;
                    end else if (pos_reg == 16'd2) begin
                        len_high_next = in_byte;
                    end else if (pos_reg == 16'd3) begin
                        frame_last_next = frame_len - 16'd1;
                        rec_end_next    = frame_len - TRAILER_BYTES;
                        if (frame_len < HARD_MIN_LEN ||
                            frame_len < {8'd0, cfg.min_frame_length}) begin
                            bad_len = 1'b1;
                        end
                    end else if (pos_reg == 16'd4) begin
                        if (in_byte == TRANSFER_CODE) flags_next[1] = 1'b1;
                    end else if (pos_reg == 16'd5) begin
                        frame_id_next = in_byte;
                    end else if (pos_reg >= RECORD_START) begin
                        // record region: data bytes, then header fields
                        if (data_rem_reg != 16'd0) begin
                            have_a              = emit;
                            res_a.kind          = KIND_DATA;
                            res_a.record_id     = rec_id_reg;
                            res_a.record_length = rec_len_reg;
                            res_a.data_byte     = in_byte;
                            data_rem_next       = data_rem_reg - 16'd1;
                        end else if (field_idx_reg != 2'd0 || pos_reg < rec_end_reg) begin
                            case (field_idx_reg)
                                2'd0: begin
                                    rec_id_next    = {in_byte, 8'h00};
                                    field_idx_next = 2'd1;
                                end
                                2'd1: begin
                                    rec_id_next    = {rec_id_reg[15:8], in_byte};
                                    field_idx_next = 2'd2;
                                end
                                2'd2: begin
                                    rec_len_next   = {in_byte, 8'h00};
                                    field_idx_next = 2'd3;
                                end
                                default: begin
                                    rec_len_next        = new_len;
                                    field_idx_next      = 2'd0;
                                    data_rem_next       = new_len;
                                    have_a              = emit;
                                    res_a.kind          = KIND_HEADER;
                                    res_a.record_id     = rec_id_reg;
                                    res_a.record_length = new_len;
                                end
                            endcase
                        end
                    end

                    // frame end or early reject
                    if (bad_len) begin
                        have_a       = 1'b1;
                        res_a.kind   = KIND_END;
                        res_a.status = ST_BAD_LENGTH;
                        phase_next   = PH_HUNT;
                    end else if (pos_reg[15:2] != 14'd0 && pos_reg == frame_last_reg) begin
                        have_b         = 1'b1;
                        res_b.kind     = KIND_END;
                        res_b.frame_id = frame_id_reg;
                        if (in_byte != cfg.end_marker) res_b.status = ST_BAD_TAIL;
                        else if (!flags_reg[0])        res_b.status = ST_BAD_VERSION;
                        else if (!flags_reg[1])        res_b.status = ST_BAD_TRANSFER;
                        else                           res_b.status = ST_OK;
                        phase_next = PH_HUNT;
                    end else begin
                        pos_next = pos_reg + 16'd1;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end

        // pack results, last flag on the final one
        push = '0;
        if (have_a && have_b) begin
            push.n       = 2'd2;
            push.r0      = res_a;
            push.r1      = res_b;
            push.r1.last = 1'b1;
        end else if (have_a) begin
            push.n       = 2'd1;
            push.r0      = res_a;
            push.r0.last = 1'b1;
        end else if (have_b) begin
            push.n       = 2'd1;
            push.r0      = res_b;
            push.r0.last = 1'b1;
        end
    end

endmodule

/* rtl/tlvp_queue.sv */
// Back end: short result queue, two writes and one read per cycle.
module tlvp_queue
    import tlvp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  space,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    res_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               pop;
    logic [Q_PTR_W-1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + Q_PTR_W'(1);
    assign space        = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign out_res      = entry_reg[rd_ptr_reg];

    // pointer and fill arithmetic
    always_comb begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) entry_reg[wr_ptr_reg]   <= push.r0;
        if (push.n == 2'd2) entry_reg[wr_ptr_plus1] <= push.r1;
    end

endmodule

/* dv/frame_receiver_tlv_parser_core_tb.sv */
// Self-checking testbench for the framed TLV stream parser: random frames against a local parser model.
module frame_receiver_tlv_parser_core_tb;
    import tlvp_pkg::*;

    localparam int FRAME_BYTE_GOAL = 1650;
    localparam int NUM_PHASES      = 9;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Kinds of damage the frame generator can put into a frame
    typedef enum {
        FLAW_NONE,
        FLAW_VERSION,
        FLAW_TRANSFER,
        FLAW_TAIL,
        FLAW_SHORT,
        FLAW_SKEW
    } frame_flaw_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_START_MARKER;
    logic [7:0]  cfg_data = 8'h00;

    frame_receiver_tlv_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Stimulus side
    logic [7:0]  byte_backlog[$];
    cfg_t        stim_cfg;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;
    bit          rx_hold = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int          frame_bytes = 0;
    int          noise_bytes = 0;
    int          frames_queued = 0;
    int          settings_applied = 1;

    // Parser model state and its copy of the registers
    cfg_t        parser_cfg;
    phase_t      prs_phase;
    logic [15:0] prs_pos;
    logic [15:0] prs_len;
    logic [7:0]  len_hi;
    logic [7:0]  held_fid;
    logic [1:0]  hdr_ok;
    logic [1:0]  field_idx;
    logic [15:0] rec_id;
    logic [15:0] rec_len;
    logic [15:0] data_left;
    res_t        pending_results[$];

    // Scoreboard counters
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          bytes_accepted = 0;
    int          end_tally[0:7];
    int          quiet_cycles = 0;

    function automatic int unsigned idle_draw(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Advance the parser model by one accepted byte and queue the results it owes
    task automatic parse_byte(input logic [7:0] b);
        res_t        made[$];
        res_t        r;
        logic [15:0] p;
        logic        emit;
        status_t     st;
        if (prs_phase == PH_HUNT) begin
            if (b == parser_cfg.start_marker) begin
                prs_phase = PH_FRAME;
                prs_pos   = 16'd1;
                prs_len   = '0;
                len_hi    = '0;
                held_fid  = '0;
                hdr_ok    = '0;
                field_idx = '0;
                rec_id    = '0;
                rec_len   = '0;
                data_left = '0;
            end
            return;
        end
        p = prs_pos;
        emit = (hdr_ok == 2'b11);
        if (p == 16'd1) begin
            if (b == parser_cfg.expected_version) hdr_ok[0] = 1'b1;
        end else if (p == 16'd2) begin
            len_hi = b;
        end else if (p == 16'd3) begin
            prs_len = {len_hi, b};
            // declared length too small: reject right away
            if (prs_len < HARD_MIN_LEN || prs_len < {8'd0, parser_cfg.min_frame_length}) begin
                r = '0;
                r.kind = KIND_END;
                r.status = ST_BAD_LENGTH;
                r.last = 1'b1;
                pending_results.push_back(r);
                prs_phase = PH_HUNT;
                return;
            end
        end else if (p == 16'd4) begin
            if (b == TRANSFER_CODE) hdr_ok[1] = 1'b1;
        end else if (p == 16'd5) begin
            held_fid = b;
        end else if (p >= RECORD_START) begin
            if (data_left != 0) begin
                if (emit) begin
                    r = '0;
                    r.kind = KIND_DATA;
                    r.record_id = rec_id;
                    r.record_length = rec_len;
                    r.data_byte = b;
                    made.push_back(r);
                end
                data_left = data_left - 16'd1;
            end else if (field_idx != 0 || p < prs_len - TRAILER_BYTES) begin
                // record header: id high, id low, length high, length low
                case (field_idx)
                    2'd0: begin
                        rec_id = {b, 8'h00};
                        field_idx = 2'd1;
                    end
                    2'd1: begin
                        rec_id = rec_id | {8'h00, b};
                        field_idx = 2'd2;
                    end
                    2'd2: begin
                        rec_len = {b, 8'h00};
                        field_idx = 2'd3;
                    end
                    default: begin
                        rec_len = rec_len | {8'h00, b};
                        field_idx = 2'd0;
                        data_left = rec_len;
                        if (emit) begin
                            r = '0;
                            r.kind = KIND_HEADER;
                            r.record_id = rec_id;
                            r.record_length = rec_len;
                            made.push_back(r);
                        end
                    end
                endcase
            end
        end
        // last byte of the frame: end status, tail checked first
        if (p >= 16'd4 && p == prs_len - 16'd1) begin
            if (b != parser_cfg.end_marker) st = ST_BAD_TAIL;
            else if (!hdr_ok[0])            st = ST_BAD_VERSION;
            else if (!hdr_ok[1])            st = ST_BAD_TRANSFER;
            else                            st = ST_OK;
            r = '0;
            r.kind = KIND_END;
            r.frame_id = held_fid;
            r.status = st;
            made.push_back(r);
            prs_phase = PH_HUNT;
        end else begin
            prs_pos = prs_pos + 16'd1;
        end
        if (made.size() != 0) made[$].last = 1'b1;
        foreach (made[i]) pending_results.push_back(made[i]);
    endtask

    task automatic report_result(input string what, input res_t want, input res_t seen);
        if (mismatch_count < 10)
            $display("%0t %s: expected kind %0d id %h len %h data %h frame %h st %0d last %b",
                     $time, what, want.kind, want.record_id, want.record_length,
                     want.data_byte, want.frame_id, want.status, want.last);
        if (mismatch_count < 10)
            $display("    got kind %0d id %h len %h data %h frame %h st %0d last %b pad %h",
                     seen.kind, seen.record_id, seen.record_length, seen.data_byte,
                     seen.frame_id, seen.status, seen.last, m_tdata[55:51]);
        mismatch_count++;
    endtask

    // Byte stream driver, fed from the backlog
    always @(posedge aclk) begin : byte_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_wait != 0) begin
                s_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (byte_backlog.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= byte_backlog.pop_front();
                send_wait <= idle_draw(send_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random back-pressure and an optional long hold
    always @(posedge aclk) begin : result_receiver
        int unsigned w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end else if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                w = idle_draw(recv_quiet);
                if (w != 0) begin
                    m_tready <= 1'b0;
                    recv_wait <= w - 1;
                end
            end
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check results, predict from accepted bytes, then track register writes
    always @(posedge aclk) begin : result_monitor
        res_t seen;
        res_t want;
        if (!aresetn) begin
            parser_cfg = {START_MARKER_RST, END_MARKER_RST, VERSION_RST, MIN_LEN_RST};
            prs_phase = PH_HUNT;
            prs_pos   = '0;
            prs_len   = '0;
            len_hi    = '0;
            held_fid  = '0;
            hdr_ok    = '0;
            field_idx = '0;
            rec_id    = '0;
            rec_len   = '0;
            data_left = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.kind          = kind_t'(m_tuser);
                seen.record_id     = m_tdata[15:0];
                seen.record_length = m_tdata[31:16];
                seen.data_byte     = m_tdata[39:32];
                seen.frame_id      = m_tdata[47:40];
                seen.status        = status_t'(m_tdata[50:48]);
                seen.last          = m_tlast;
                results_checked++;
                if (pending_results.size() == 0) begin
                    report_result("unexpected result", '0, seen);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want || m_tdata[55:51] !== 5'd0)
                        report_result("result mismatch", want, seen);
                    else if (seen.kind == KIND_END)
                        end_tally[seen.status]++;
                end
            end
            // a byte taken at the same edge as a register write still sees the old value
            if (s_tvalid && s_tready) begin
                bytes_accepted++;
                parse_byte(s_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_MARKER: parser_cfg.start_marker = cfg_data;
                    CFG_END_MARKER:   parser_cfg.end_marker = cfg_data;
                    CFG_VERSION:      parser_cfg.expected_version = cfg_data;
                    CFG_MIN_LENGTH:   parser_cfg.min_frame_length = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_MARKER: stim_cfg.start_marker = val;
            CFG_END_MARKER:   stim_cfg.end_marker = val;
            CFG_VERSION:      stim_cfg.expected_version = val;
            CFG_MIN_LENGTH:   stim_cfg.min_frame_length = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] sm, input logic [7:0] em,
                                  input logic [7:0] ver, input logic [7:0] min_len);
        write_reg(CFG_START_MARKER, sm);
        write_reg(CFG_END_MARKER, em);
        write_reg(CFG_VERSION, ver);
        write_reg(CFG_MIN_LENGTH, min_len);
        settings_applied++;
    endtask

    // Wait until all bytes are sent and every result has come back
    task automatic wait_drained();
        do @(posedge aclk);
        while (byte_backlog.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic queue_noise(input int count, input bit avoid_marker);
        logic [7:0] nb;
        repeat (count) begin
            nb = 8'($urandom);
            while (avoid_marker && nb == stim_cfg.start_marker) nb = 8'($urandom);
            byte_backlog.push_back(nb);
            noise_bytes++;
        end
    endtask

    // Build one frame of random records, padded to pad_to bytes, with an optional flaw
    task automatic queue_frame(input frame_flaw_t flaw, input int pad_to);
        logic [7:0]  region[$];
        logic [15:0] rid;
        int          n_rec;
        int          dlen;
        int          total;
        n_rec = $urandom_range(0, 3);
        repeat (n_rec) begin
            rid = 16'($urandom);
            dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
            region.push_back(rid[15:8]);
            region.push_back(rid[7:0]);
            // now and then declare far more data than follows, so the frame end clips it
            region.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
            region.push_back(8'(dlen));
            repeat (dlen) region.push_back(8'($urandom));
        end
        // empty records stretch the frame to the minimum length
        while (region.size() + 14 < pad_to) begin
            rid = 16'($urandom);
            region.push_back(rid[15:8]);
            region.push_back(rid[7:0]);
            region.push_back(8'h00);
            region.push_back(8'h00);
        end
        total = region.size() + 14;
        if (flaw == FLAW_SHORT)
            total = $urandom_range(0, stim_cfg.min_frame_length - 1);
        else if (flaw == FLAW_SKEW)
            total = total + $urandom_range(0, 10) - 4;
        if (total < 0) total = 0;

        byte_backlog.push_back(stim_cfg.start_marker);
        byte_backlog.push_back(flaw == FLAW_VERSION ?
            stim_cfg.expected_version ^ 8'($urandom_range(1, 255)) : stim_cfg.expected_version);
        byte_backlog.push_back(total[15:8]);
        byte_backlog.push_back(total[7:0]);
        frame_bytes += 4;
        if (flaw != FLAW_SHORT) begin
            byte_backlog.push_back(flaw == FLAW_TRANSFER ?
                TRANSFER_CODE ^ 8'($urandom_range(1, 255)) : TRANSFER_CODE);
            byte_backlog.push_back(8'($urandom));
            repeat (5) byte_backlog.push_back(8'($urandom));
            foreach (region[i]) byte_backlog.push_back(region[i]);
            repeat (2) byte_backlog.push_back(8'($urandom));
            byte_backlog.push_back(flaw == FLAW_TAIL ?
                stim_cfg.end_marker ^ 8'($urandom_range(1, 255)) : stim_cfg.end_marker);
            frame_bytes += region.size() + 10;
        end
        frames_queued++;
    endtask

    initial begin : stimulus
        int          ph;
        int          pick;
        frame_flaw_t flaw;
        stim_cfg = {START_MARKER_RST, END_MARKER_RST, VERSION_RST, MIN_LEN_RST};
        foreach (end_tally[i]) end_tally[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: hunt noise, a too-short frame, then a 15-byte frame whose record
        // header runs into the trailer so the tail byte gives a header and the end status
        byte_backlog = '{8'h00, 8'hFF,
                         START_MARKER_RST, VERSION_RST, 8'h00, 8'h05,
                         START_MARKER_RST, VERSION_RST, 8'h00, 8'h0F, TRANSFER_CODE, 8'hA5,
                         8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01,
                         8'h12, 8'h34, 8'h00, 8'hFF};
        noise_bytes += 2;
        frame_bytes += 19;
        frames_queued += 2;
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: apply_settings(8'h00, 8'h00, 8'hFF, 8'd14);
                2: apply_settings(8'hFF, 8'hFF, 8'h00, 8'd255);
                3: apply_settings(START_MARKER_RST, END_MARKER_RST, VERSION_RST, MIN_LEN_RST);
                NUM_PHASES - 1:
                    apply_settings(START_MARKER_RST, END_MARKER_RST, VERSION_RST, MIN_LEN_RST);
                default:
                    apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom_range(14, 40)));
            endcase
            @(posedge aclk);
            send_quiet <= (ph % 3 == 1) || (ph == 3);
            recv_quiet <= (ph % 3 == 1);
            if (ph == 3) rx_hold <= 1'b1;
            // one long frame with a length above 255
            if (ph == 5) queue_frame(FLAW_NONE, 272);

            while (frame_bytes < FRAME_BYTE_GOAL * (ph + 1) / NUM_PHASES) begin
                pick = $urandom_range(0, 19);
                case (pick)
                    12:      flaw = FLAW_VERSION;
                    13:      flaw = FLAW_TRANSFER;
                    14:      flaw = FLAW_TAIL;
                    15:      flaw = FLAW_SHORT;
                    16, 17:  flaw = FLAW_SKEW;
                    default: flaw = FLAW_NONE;
                endcase
                if (pick >= 18) queue_noise($urandom_range(1, 8), 1'b0);
                else            queue_noise($urandom_range(0, 2), 1'b1);
                queue_frame(flaw, stim_cfg.min_frame_length);
            end

            // receiver stalls while the sender keeps offering bytes
            if (ph == 3) begin
                repeat (PRESSURE_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            wait_drained();
        end

        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end
        $display("Covered %0d bytes (%0d in %0d frames, %0d hunt noise), %0d settings, %0d results",
                 bytes_accepted, frame_bytes, frames_queued, noise_bytes, settings_applied,
                 results_checked);
        $display("End status: ok %0d, bad tail %0d, version %0d, transfer %0d, length %0d",
                 end_tally[ST_OK], end_tally[ST_BAD_TAIL], end_tally[ST_BAD_VERSION],
                 end_tally[ST_BAD_TRANSFER], end_tally[ST_BAD_LENGTH]);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tlvp_pkg.sv
rtl/tlvp_front.sv
rtl/tlvp_queue.sv
rtl/frame_receiver_tlv_parser_core.sv
dv/frame_receiver_tlv_parser_core_tb.sv
